// File: hdl/stb_pkg.sv
// Shared types and constants for the band tracker: field widths, register
// indexes, reset values and trend codes. No dependencies.
`default_nettype none

package stb_pkg;

  // Default price word width (signed fixed point).
  localparam int PRICE_WIDTH_DEF = 32;

  // Configuration register widths and port sizing.
  localparam int PERIOD_W   = 8;
  localparam int MULT_W     = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MULT   = 1'b1;

  // Register reset values.
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 8'd10;
  localparam logic [MULT_W-1:0]   MULT_RST   = 16'd768;

  // Bar counter width and its saturation value.
  localparam int               BARS_W   = 9;
  localparam logic [BARS_W-1:0] BARS_MAX = 9'd511;

  // Trend codes, also the two-bit signed direction on the result channel.
  localparam int              TREND_W    = 2;
  localparam logic [TREND_W-1:0] TREND_NONE = 2'b00;
  localparam logic [TREND_W-1:0] TREND_UP   = 2'b01;
  localparam logic [TREND_W-1:0] TREND_DOWN = 2'b11;

endpackage

`default_nettype wire

// File: hdl/stb_if.sv
// Valid/ready channel interfaces for price bars in and trend results out.
// Depends on stb_pkg for the default price width and the trend code width.
`default_nettype none

interface stb_bar_if #(
  parameter int PRICE_WIDTH = stb_pkg::PRICE_WIDTH_DEF
);
  import stb_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [PRICE_WIDTH-1:0] bar_high;
  logic signed [PRICE_WIDTH-1:0] bar_low;
  logic signed [PRICE_WIDTH-1:0] bar_close;
  logic                          series_start;

  modport source (output valid, bar_high, bar_low, bar_close, series_start, input ready);
  modport sink   (input valid, bar_high, bar_low, bar_close, series_start, output ready);
endinterface

interface stb_res_if #(
  parameter int PRICE_WIDTH = stb_pkg::PRICE_WIDTH_DEF
);
  import stb_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [PRICE_WIDTH-1:0] trend_level;
  logic signed [TREND_W-1:0]     trend_direction;
  logic [PRICE_WIDTH-2:0]        range_average;

  modport source (output valid, trend_level, trend_direction, range_average, input ready);
  modport sink   (input valid, trend_level, trend_direction, range_average, output ready);
endinterface

`default_nettype wire

// File: hdl/supertrend_band_tracker.sv
// Streaming Supertrend band tracker with a Wilder average true range.
// Depends on stb_pkg and the channel interfaces in stb_if.sv.
//
// Usage: price bars (high, low, close, series_start) arrive on bar_i, one
// beat per bar, and every bar yields exactly one result beat on res_o
// (trend level, direction, average true range). Bars before the seed bar
// give an all-zero result. The period and band multiplier are written on
// the plain configuration port while the block is idle.
// Timing: one shared adder/subtractor does all arithmetic under a small
// sequencer, so the block takes one bar at a time and drops ready while it
// works. The cost of a bar is set by the one-bit-per-cycle restoring
// divider (PRICE_WIDTH steps), the 16-step serial band multiply and, when
// smoothing, the 8-step multiply by P - 1.
// Output: the result sits in an output register, so the next bar is taken
// while a result still waits. If the receiver stalls, the sequencer holds
// the finished result in its last state until the output register frees.
// Reset: an asynchronous low reset clears the series state and restores the
// period (10) and multiplier (3.0 in Q8.8); res_o shows no beat.
`default_nettype none

module supertrend_band_tracker #(
  parameter int PRICE_WIDTH = stb_pkg::PRICE_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [stb_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [stb_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  stb_bar_if.sink                        bar_i,
  stb_res_if.source                      res_o
);
  import stb_pkg::*;

  // Shared datapath width: covers the 16-bit-multiplier product.
  localparam int PW = PRICE_WIDTH;
  localparam int W  = PRICE_WIDTH + MULT_W;
  localparam int CW = $clog2(PRICE_WIDTH);

  localparam logic [PW-1:0] PMAX = {1'b0, {(PW - 1){1'b1}}};
  localparam logic [PW-1:0] PMIN = {1'b1, {(PW - 1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TR0,
    ST_TR1,
    ST_TR2,
    ST_SUM,
    ST_SMUL,
    ST_SADD,
    ST_DIV,
    ST_BMUL,
    ST_HL2,
    ST_BUP,
    ST_BLO,
    ST_RATCHET,
    ST_TREND,
    ST_DONE
  } st_e;

  // Configuration registers.
  logic [PERIOD_W-1:0] period_q;
  logic [MULT_W-1:0]   mult_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RST;
      mult_q   <= MULT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PERIOD: period_q <= cfg_wdata_i[PERIOD_W-1:0];
        CFG_MULT:   mult_q   <= cfg_wdata_i[MULT_W-1:0];
        default:    ;
      endcase
    end
  end

  // A period of zero acts as one.
  logic [PERIOD_W-1:0] p_eff;
  logic [PERIOD_W-1:0] p_m1;
  assign p_eff = (period_q == '0) ? PERIOD_W'(1) : period_q;
  assign p_m1  = p_eff - PERIOD_W'(1);

  // Sequencer, bar and series state.
  st_e                 state_q;
  logic signed [PW-1:0] hi_q, lo_q, cl_q, pc_q;
  logic [BARS_W-1:0]   bars_q, idx_q;
  logic [PW-1:0]       tr_q;
  logic [PW+7:0]       sum_q;
  logic [PW-1:0]       atr_q;
  logic signed [PW-1:0] ub_q, lb_q, bu_q, bl_q, hl2_q;
  logic [TREND_W-1:0]  trend_q;
  logic                first_q, active_q;
  logic [W-1:0]        acc_q;
  logic [BARS_W-1:0]   rem_q;
  logic [PERIOD_W-1:0] div_q;
  logic [CW-1:0]       cnt_q;

  // Output register.
  logic                 ovalid_q;
  logic signed [PW-1:0] olevel_q;
  logic [TREND_W-1:0]   odir_q;
  logic [PW-2:0]        oavg_q;

  // Shared adder/subtractor and its operand selection.
  logic [W-1:0] alu_a, alu_b, alu_res;
  logic         alu_sub;
  logic         hi_lt_pc, lo_lt_pc;
  logic [W-1:0] hi_x, lo_x, pc_x, hl2_x, atr_x, tr_x;
  logic [BARS_W-1:0] rem_sh;

  assign hi_x   = {{(W - PW){hi_q[PW-1]}}, hi_q};
  assign lo_x   = {{(W - PW){lo_q[PW-1]}}, lo_q};
  assign pc_x   = {{(W - PW){pc_q[PW-1]}}, pc_q};
  assign hl2_x  = {{(W - PW){hl2_q[PW-1]}}, hl2_q};
  assign atr_x  = {{(W - PW){1'b0}}, atr_q};
  assign tr_x   = {{(W - PW){1'b0}}, tr_q};
  assign hi_lt_pc = hi_q < pc_q;
  assign lo_lt_pc = lo_q < pc_q;
  // Divider: shift in the next dividend bit beside the partial remainder.
  assign rem_sh = {rem_q[BARS_W-2:0], acc_q[PW-1]};

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      ST_TR0: begin
        alu_a   = hi_x;
        alu_b   = lo_x;
        alu_sub = 1'b1;
      end
      ST_TR1: begin
        alu_a   = hi_lt_pc ? pc_x : hi_x;
        alu_b   = hi_lt_pc ? hi_x : pc_x;
        alu_sub = 1'b1;
      end
      ST_TR2: begin
        alu_a   = lo_lt_pc ? pc_x : lo_x;
        alu_b   = lo_lt_pc ? lo_x : pc_x;
        alu_sub = 1'b1;
      end
      ST_SUM: begin
        alu_a = {{(W - PW - 8){1'b0}}, sum_q};
        alu_b = tr_x;
      end
      ST_SMUL: begin
        alu_a = {acc_q[W-2:0], 1'b0};
        alu_b = p_m1[cnt_q[2:0]] ? atr_x : '0;
      end
      ST_SADD: begin
        alu_a = acc_q;
        alu_b = tr_x;
      end
      ST_DIV: begin
        alu_a   = {{(W - BARS_W){1'b0}}, rem_sh};
        alu_b   = {{(W - PERIOD_W){1'b0}}, div_q};
        alu_sub = 1'b1;
      end
      ST_BMUL: begin
        alu_a = {acc_q[W-2:0], 1'b0};
        alu_b = mult_q[cnt_q[3:0]] ? atr_x : '0;
      end
      ST_HL2: begin
        alu_a = hi_x;
        alu_b = lo_x;
      end
      ST_BUP: begin
        alu_a = hl2_x;
        alu_b = {8'd0, acc_q[W-1:8]};
      end
      ST_BLO: begin
        alu_a   = hl2_x;
        alu_b   = {8'd0, acc_q[W-1:8]};
        alu_sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign alu_res = alu_a + (alu_b ^ {W{alu_sub}}) + W'(alu_sub);

  // Candidate true range beats the running maximum.
  logic tr_take;
  assign tr_take = $signed(alu_res) > $signed(acc_q);

  // Trial subtraction of the divider succeeds when the result is not negative.
  logic div_ge;
  assign div_ge = ~alu_res[W-1];

  // Saturation of a band sum to the signed price range.
  logic         band_fits;
  logic [PW-1:0] band_sat;
  assign band_fits = (&alu_res[W-1:PW-1]) | ~(|alu_res[W-1:PW-1]);
  assign band_sat  = band_fits ? alu_res[PW-1:0] : (alu_res[W-1] ? PMIN : PMAX);

  logic seed_now;
  assign seed_now = idx_q >= {1'b0, p_eff};

  logic [BARS_W-1:0] idx_new;
  assign idx_new = bar_i.series_start ? '0 : bars_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      hi_q     <= '0;
      lo_q     <= '0;
      cl_q     <= '0;
      pc_q     <= '0;
      bars_q   <= '0;
      idx_q    <= '0;
      tr_q     <= '0;
      sum_q    <= '0;
      atr_q    <= '0;
      ub_q     <= '0;
      lb_q     <= '0;
      bu_q     <= '0;
      bl_q     <= '0;
      hl2_q    <= '0;
      trend_q  <= TREND_NONE;
      first_q  <= 1'b0;
      active_q <= 1'b0;
      acc_q    <= '0;
      rem_q    <= '0;
      div_q    <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      olevel_q <= '0;
      odir_q   <= TREND_NONE;
      oavg_q   <= '0;
    end else begin
      // A taken beat clears valid; a finished result reloads it in the same cycle.
      if (ovalid_q && res_o.ready && (state_q != ST_DONE)) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (bar_i.valid) begin
            hi_q     <= bar_i.bar_high;
            lo_q     <= bar_i.bar_low;
            cl_q     <= bar_i.bar_close;
            first_q  <= 1'b0;
            active_q <= 1'b0;
            idx_q    <= idx_new;
            bars_q   <= (idx_new == BARS_MAX) ? BARS_MAX : idx_new + BARS_W'(1);
            if (bar_i.series_start) begin
              pc_q    <= '0;
              sum_q   <= '0;
              atr_q   <= '0;
              ub_q    <= '0;
              lb_q    <= '0;
              trend_q <= TREND_NONE;
            end
            // Bar zero only records its close.
            state_q <= (idx_new == '0) ? ST_DONE : ST_TR0;
          end
        end
        ST_TR0: begin
          acc_q   <= alu_res;
          state_q <= ST_TR1;
        end
        ST_TR1: begin
          if (tr_take) begin
            acc_q <= alu_res;
          end
          state_q <= ST_TR2;
        end
        ST_TR2: begin
          tr_q <= tr_take ? alu_res[PW-1:0] : acc_q[PW-1:0];
          if (trend_q == TREND_NONE) begin
            state_q <= ST_SUM;
          end else begin
            acc_q   <= '0;
            cnt_q   <= CW'(PERIOD_W - 1);
            state_q <= ST_SMUL;
          end
        end
        ST_SUM: begin
          sum_q <= alu_res[PW+7:0];
          if (seed_now) begin
            // Seed: divide the warm-up sum by the number of bars summed.
            first_q <= 1'b1;
            rem_q   <= alu_res[PW+8:PW];
            acc_q   <= {{(W - PW){1'b0}}, alu_res[PW-1:0]};
            div_q   <= idx_q[PERIOD_W-1:0];
            cnt_q   <= CW'(PW - 1);
            state_q <= ST_DIV;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_SMUL: begin
          acc_q <= alu_res;
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == '0) begin
            state_q <= ST_SADD;
          end
        end
        ST_SADD: begin
          rem_q   <= alu_res[PW+8:PW];
          acc_q   <= {{(W - PW){1'b0}}, alu_res[PW-1:0]};
          div_q   <= p_eff;
          cnt_q   <= CW'(PW - 1);
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          rem_q <= div_ge ? alu_res[BARS_W-1:0] : rem_sh;
          if (cnt_q == '0) begin
            atr_q   <= {acc_q[PW-2:0], div_ge};
            acc_q   <= '0;
            cnt_q   <= CW'(MULT_W - 1);
            state_q <= ST_BMUL;
          end else begin
            acc_q <= {{(W - PW){1'b0}}, acc_q[PW-2:0], div_ge};
            cnt_q <= cnt_q - CW'(1);
          end
        end
        ST_BMUL: begin
          acc_q <= alu_res;
          cnt_q <= cnt_q - CW'(1);
          if (cnt_q == '0) begin
            state_q <= ST_HL2;
          end
        end
        ST_HL2: begin
          // Arithmetic shift gives the floor of the midpoint.
          hl2_q   <= alu_res[PW:1];
          state_q <= ST_BUP;
        end
        ST_BUP: begin
          bu_q    <= band_sat;
          state_q <= ST_BLO;
        end
        ST_BLO: begin
          bl_q    <= band_sat;
          state_q <= ST_RATCHET;
        end
        ST_RATCHET: begin
          active_q <= 1'b1;
          if (first_q) begin
            ub_q    <= bu_q;
            lb_q    <= bl_q;
            trend_q <= (cl_q <= bu_q) ? TREND_DOWN : TREND_UP;
            state_q <= ST_DONE;
          end else begin
            // The upper band only moves down unless the last close broke it,
            // and the lower band mirrors that.
            if (bu_q < ub_q || pc_q > ub_q) begin
              ub_q <= bu_q;
            end
            if (bl_q > lb_q || pc_q < lb_q) begin
              lb_q <= bl_q;
            end
            state_q <= ST_TREND;
          end
        end
        ST_TREND: begin
          if (trend_q == TREND_UP) begin
            if (cl_q < lb_q) begin
              trend_q <= TREND_DOWN;
            end
          end else if (cl_q > ub_q) begin
            trend_q <= TREND_UP;
          end
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!ovalid_q || res_o.ready) begin
            ovalid_q <= 1'b1;
            pc_q     <= cl_q;
            if (active_q) begin
              olevel_q <= (trend_q == TREND_UP) ? lb_q : ub_q;
              odir_q   <= (trend_q == TREND_UP) ? TREND_UP : TREND_DOWN;
              oavg_q   <= atr_q[PW-1] ? {(PW - 1){1'b1}} : atr_q[PW-2:0];
            end else begin
              olevel_q <= '0;
              odir_q   <= TREND_NONE;
              oavg_q   <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign bar_i.ready           = (state_q == ST_IDLE);
  assign res_o.valid           = ovalid_q;
  assign res_o.trend_level     = olevel_q;
  assign res_o.trend_direction = odir_q;
  assign res_o.range_average   = oavg_q;

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench for supertrend_band_tracker: a scoreboard class predicts every result
// beat from the accepted bars, and plain tasks drive bars, results and register writes.
// Depends on stb_pkg (hdl/stb_pkg.sv), the channel interfaces (hdl/stb_if.sv) and the block.
`timescale 1ns / 100ps
`default_nettype none

import stb_pkg::*;

typedef struct packed {
  logic signed [PRICE_WIDTH_DEF-1:0] high;
  logic signed [PRICE_WIDTH_DEF-1:0] low;
  logic signed [PRICE_WIDTH_DEF-1:0] close;
  logic                              start;
} price_bar_t;

typedef struct packed {
  logic signed [PRICE_WIDTH_DEF-1:0] level;
  logic [TREND_W-1:0]                direction;
  logic [PRICE_WIDTH_DEF-2:0]        average;
} trend_result_t;

class trend_scoreboard;
  localparam longint PRICE_MAX = (longint'(1) <<< (PRICE_WIDTH_DEF - 1)) - 1;
  localparam longint PRICE_MIN = -PRICE_MAX - 1;

  logic [PERIOD_W-1:0] period;
  logic [MULT_W-1:0]   multiplier;
  int unsigned         bars_taken;
  longint              last_close;
  longint unsigned     range_sum;
  longint unsigned     avg_range;
  longint              upper_band;
  longint              lower_band;
  logic [TREND_W-1:0]  trend;
  trend_result_t       expected_trends[$];
  int unsigned         mismatch_count;

  function new();
    period         = PERIOD_RST;
    multiplier     = MULT_RST;
    mismatch_count = 0;
    restart_series();
  endfunction

  function void restart_series();
    bars_taken = 0;
    last_close = 0;
    range_sum  = 0;
    avg_range  = 0;
    upper_band = 0;
    lower_band = 0;
    trend      = TREND_NONE;
  endfunction

  function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == CFG_PERIOD) begin
      period = data[PERIOD_W-1:0];
    end else begin
      multiplier = data[MULT_W-1:0];
    end
  endfunction

  function longint clamp_price(longint v);
    if (v > PRICE_MAX) return PRICE_MAX;
    if (v < PRICE_MIN) return PRICE_MIN;
    return v;
  endfunction

  // Advances the indicator state by one bar and returns the result it produces.
  function trend_result_t advance_trend(price_bar_t b);
    longint          hi, lo, cl, tr, swing, hl2, up_b, lo_b;
    longint unsigned per, width, avg_shown;
    int unsigned     idx;
    bit              seed_now;
    trend_result_t   r;
    hi  = b.high;
    lo  = b.low;
    cl  = b.close;
    per = (period == 0) ? 1 : period;
    r   = '0;
    if (b.start) restart_series();
    idx = bars_taken;
    if (bars_taken < BARS_MAX) bars_taken++;
    if (idx > 0) begin
      tr = hi - lo;
      swing = hi - last_close;
      if (swing < 0) swing = -swing;
      if (swing > tr) tr = swing;
      swing = lo - last_close;
      if (swing < 0) swing = -swing;
      if (swing > tr) tr = swing;
      seed_now = 1'b0;
      if (trend == TREND_NONE) begin
        range_sum += longint'(tr);
        if (idx >= per) begin
          avg_range = range_sum / idx;
          seed_now  = 1'b1;
        end
      end else begin
        avg_range = (avg_range * (per - 1) + longint'(tr)) / per;
      end
      if (trend != TREND_NONE || seed_now) begin
        hl2   = (hi + lo) >>> 1;
        width = (avg_range >> 8) * multiplier + (((avg_range & 255) * multiplier) >> 8);
        up_b  = clamp_price(hl2 + longint'(width));
        lo_b  = clamp_price(hl2 - longint'(width));
        if (seed_now) begin
          upper_band = up_b;
          lower_band = lo_b;
          trend = (cl <= upper_band) ? TREND_DOWN : TREND_UP;
        end else begin
          if (up_b < upper_band || last_close > upper_band) upper_band = up_b;
          if (lo_b > lower_band || last_close < lower_band) lower_band = lo_b;
          if (trend == TREND_UP) begin
            if (cl < lower_band) trend = TREND_DOWN;
          end else if (cl > upper_band) begin
            trend = TREND_UP;
          end
        end
        r.level     = (trend == TREND_UP) ? lower_band[PRICE_WIDTH_DEF-1:0]
                                          : upper_band[PRICE_WIDTH_DEF-1:0];
        r.direction = trend;
        avg_shown   = (avg_range > PRICE_MAX) ? PRICE_MAX : avg_range;
        r.average   = avg_shown[PRICE_WIDTH_DEF-2:0];
      end
    end
    last_close = cl;
    return r;
  endfunction

  function void track_bar(price_bar_t b);
    expected_trends.insert(expected_trends.size(), advance_trend(b));
  endfunction

  function void report(string field, longint unsigned want, longint unsigned got);
    mismatch_count++;
    $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
  endfunction

  function void check_result(trend_result_t got);
    trend_result_t want;
    if (expected_trends.size() == 0) begin
      report("unexpected result beat", 64'(0), 64'(got.level));
      return;
    end
    want = expected_trends.pop_front();
    if (got.level !== want.level) report("trend_level", 64'(want.level), 64'(got.level));
    if (got.direction !== want.direction)
      report("trend_direction", 64'(want.direction), 64'(got.direction));
    if (got.average !== want.average)
      report("range_average", 64'(want.average), 64'(got.average));
  endfunction
endclass

module testbench;
  localparam int          PW        = PRICE_WIDTH_DEF;
  localparam longint      PMAX      = (longint'(1) <<< (PW - 1)) - 1;
  localparam longint      PMIN      = -PMAX - 1;
  // Gives the final drain some slack beyond the slowest bar.
  localparam int          DRAIN     = 100;
  // Covers roughly 1350 bars at the slowest bar cost, with a wide margin.
  localparam int unsigned RUN_LIMIT = 600_000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  stb_bar_if #(.PRICE_WIDTH(PW)) bar_if ();
  stb_res_if #(.PRICE_WIDTH(PW)) res_if ();

  supertrend_band_tracker #(.PRICE_WIDTH(PW)) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .bar_i       (bar_if),
    .res_o       (res_if)
  );

  trend_scoreboard sb = new();

  // Idle state of each side. When a side is quiet it never waits, which gives
  // stretches of back-to-back beats between the randomly gapped ones.
  bit src_quiet = 1'b0;
  bit sink_quiet = 1'b0;

  // Price walk used to build well-formed bar series: a midpoint that drifts in
  // one direction for a while and then reverses, with a volatility that sets
  // the scale of each series.
  longint      walk_mid = 0;
  longint      walk_drift = 0;
  int unsigned walk_vol = 1024;

  int unsigned cycle_count = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Run limit: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic price_bar_t make_bar(longint hi, longint lo, longint cl, bit start);
    price_bar_t b;
    b.high  = hi[PW-1:0];
    b.low   = lo[PW-1:0];
    b.close = cl[PW-1:0];
    b.start = start;
    return b;
  endfunction

  // Both monitors sample at the rising edge, before the block or the drivers
  // update anything, so a beat is seen exactly as the block took it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (bar_if.valid && bar_if.ready)
        sb.track_bar(make_bar(bar_if.bar_high, bar_if.bar_low, bar_if.bar_close,
                              bar_if.series_start));
      if (res_if.valid && res_if.ready)
        sb.check_result({res_if.trend_level, res_if.trend_direction, res_if.range_average});
    end
  end

  function automatic int unsigned idle_cycles(inout bit quiet);
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic longint clamp_walk(longint v);
    if (v > PMAX) return PMAX;
    if (v < PMIN) return PMIN;
    return v;
  endfunction

  // Starts a new price series somewhere in the full signed range. Some series
  // sit near zero so that both signs of the prices show up within one series.
  function automatic void reseed_walk();
    walk_mid = longint'($signed($urandom));
    if ($urandom_range(0, 1) == 0) walk_mid = walk_mid >>> 12;
    walk_vol   = 1 << $urandom_range(3, 26);
    walk_drift = longint'($urandom_range(0, walk_vol / 2));
    if ($urandom_range(0, 1) == 0) walk_drift = -walk_drift;
  endfunction

  function automatic price_bar_t walk_bar(bit start);
    longint hi, lo, cl;
    if ($urandom_range(0, 15) == 0) walk_drift = -walk_drift;
    walk_mid = clamp_walk(walk_mid + walk_drift
                          + longint'($urandom_range(0, 2 * walk_vol)) - longint'(walk_vol));
    hi = clamp_walk(walk_mid + longint'($urandom_range(0, walk_vol)));
    lo = clamp_walk(walk_mid - longint'($urandom_range(0, walk_vol)));
    cl = lo + longint'($urandom_range(0, 32'(hi - lo)));
    return make_bar(hi, lo, cl, start);
  endfunction

  // Mostly well-formed series with random content, plus about one bar in
  // twelve of pure noise. Long runs never restart the series, so the bar
  // counter reaches its saturation value.
  function automatic price_bar_t random_bar(bit long_run);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (!long_run && pick < 3) begin
      reseed_walk();
      return walk_bar(1'b1);
    end
    if (pick < 11)
      return make_bar(longint'($signed($urandom)), longint'($signed($urandom)),
                      longint'($signed($urandom)),
                      !long_run && $urandom_range(0, 7) == 0);
    return walk_bar(1'b0);
  endfunction

  // Offers one bar and returns at the edge where it is taken. Valid stays high
  // afterwards, so a following bar with no gap goes out back to back.
  task automatic send_bar(price_bar_t b);
    int unsigned gap;
    gap = idle_cycles(src_quiet);
    if (gap > 0) begin
      bar_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    bar_if.valid        <= 1'b1;
    bar_if.bar_high     <= b.high;
    bar_if.bar_low      <= b.low;
    bar_if.bar_close    <= b.close;
    bar_if.series_start <= b.start;
    do @(posedge clk_i); while (!bar_if.ready);
  endtask

  // Stops offering bars and waits until every predicted result has come back,
  // which leaves the block idle for a register write. The first edge lets the
  // monitor note a bar taken at the edge where this task starts.
  task automatic settle_block();
    bar_if.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_trends.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.write_register(idx, data);
    @(posedge clk_i);
  endtask

  // Result side: the ready line is held low for a random number of cycles
  // before each beat, then held high until a beat is taken.
  initial begin : result_sink
    int unsigned stall;
    res_if.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = idle_cycles(sink_quiet);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  initial begin : stimulus
    bit              long_run;
    int unsigned     count;
    logic [7:0]      period_word;
    logic [MULT_W-1:0] mult_word;
    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = CFG_PERIOD;
    cfg_wdata_i         = '0;
    bar_if.valid        = 1'b0;
    bar_if.bar_high     = '0;
    bar_if.bar_low      = '0;
    bar_if.bar_close    = '0;
    bar_if.series_start = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, starting from the reset period of 10. Bar zero and three
    // warm-up bars use very wide true ranges, the widest the format allows on
    // two of them, including a bar whose high lies below its low.
    send_bar(make_bar(PMAX, PMIN, 0, 1'b1));
    send_bar(make_bar(PMAX, PMIN, PMAX, 1'b0));
    send_bar(make_bar(PMIN, PMAX, PMIN, 1'b0));
    send_bar(make_bar(0, 0, -1, 1'b0));

    // Shorten the period in the middle of the warm-up. The next bar seeds the
    // average from all four summed bars; the average is far above the output
    // range and the bands clip at both ends. Junk in the upper data byte must
    // be ignored.
    settle_block();
    program_register(CFG_PERIOD, 16'hA503);
    send_bar(make_bar(32'sh0001_0000, -32'sh0001_0000, 0, 1'b0));
    send_bar(make_bar(1, 0, PMAX, 1'b0));
    send_bar(make_bar(PMIN, PMIN, PMIN, 1'b0));

    // A zero period behaves as one, and a zero multiplier collapses both bands
    // onto the midpoint, so closes on either side flip the trend both ways.
    // One bar has an odd negative high plus low, which rounds down.
    settle_block();
    program_register(CFG_PERIOD, 16'hFF00);
    program_register(CFG_MULT, 16'h0000);
    send_bar(make_bar(32'sh0002_0000, 0, 32'sh0003_0000, 1'b0));
    send_bar(make_bar(32'sh0001_0000, -32'sh0001_0000, -32'sh0002_0000, 1'b0));
    send_bar(make_bar(-1, -3, 5, 1'b0));
    send_bar(make_bar(-1, -2, -7, 1'b0));

    // Longest period and widest multiplier: a fresh series stays in warm-up.
    settle_block();
    program_register(CFG_PERIOD, 16'h00FF);
    program_register(CFG_MULT, 16'hFFFF);
    send_bar(make_bar(5, -5, 0, 1'b1));
    send_bar(make_bar(32'sh7FFF_0000, 32'sh0001_0000, 32'sh4000_0000, 1'b0));
    send_bar(make_bar(32'sh0001_0000, 32'sh7FFF_0000, 0, 1'b0));

    // Random phases. The series carries over from one phase to the next, so a
    // new period often lands in the middle of a warm-up.
    reseed_walk();
    for (int phase = 0; phase < 8; phase++) begin
      long_run = (phase == 3);
      settle_block();
      case ($urandom_range(0, 9))
        0:       period_word = 8'd0;
        1:       period_word = 8'd255;
        2:       period_word = 8'd1;
        default: period_word = 8'($urandom_range(2, 24));
      endcase
      if (long_run) period_word = 8'($urandom_range(1, 20));
      case ($urandom_range(0, 7))
        0:       mult_word = '0;
        1:       mult_word = '1;
        2:       mult_word = MULT_W'($urandom);
        default: mult_word = MULT_W'($urandom_range(128, 1024));
      endcase
      program_register(CFG_PERIOD, {8'($urandom), period_word});
      program_register(CFG_MULT, mult_word);
      count = long_run ? 560 : 110;
      for (int k = 0; k < count; k++) send_bar(random_bar(long_run));
    end

    settle_block();
    repeat (DRAIN) @(posedge clk_i);
    if (sb.mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
